### rtl/rpd_pkg.sv
// shared types and codes for the run-length palette pixel decoder
package rpd_pkg;

  localparam int unsigned COLOR_W = 32;
  localparam int unsigned POS_W   = 25;
  localparam int unsigned INDEX_W = 24;
  localparam int unsigned CFG_W   = 25;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_CTRL  = 2'd1,
    REQ_LIT   = 2'd2,
    REQ_PAL   = 2'd3
  } req_kind_t;

  // run selector, top two bits of a control byte
  typedef enum logic [1:0] {
    SEL_LIT_SHORT = 2'd0,
    SEL_LIT_LONG  = 2'd1,
    SEL_FILL      = 2'd2,
    SEL_ZERO      = 2'd3
  } run_sel_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OVER    = 2'd1,
    ERR_UNEXP   = 2'd2,
    ERR_PENDING = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LIT  = 2'd1,
    PEND_FILL = 2'd2
  } pend_kind_t;

  typedef enum logic {
    CFG_PIXEL_TOTAL = 1'b0,
    CFG_BITMAP_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         data_byte;
    logic [COLOR_W-1:0] color_word;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [INDEX_W-1:0] pixel_index;
    logic               last_of_run;
    logic [1:0]         error_code;
  } out_res_t;

endpackage

### rtl/rpd_palette.sv
// palette color memory, one write port and one registered read port
module rpd_palette #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned WIDTH   = 32,
  parameter int unsigned ADDR_W  = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [ENTRIES];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rle_palette_pixel_decoder_unit.sv
// top level of the run-length palette pixel decoder
//
// accepts one request at a time. start-image, palette-write, pending-only
// control and ignored requests do not enter the pixel loop; a request that
// yields pixels is decoded first (and reads the palette memory, whose read
// data is registered) and then enters the pixel loop, up to 63 pixels for a
// fill or zero run. the pixel loop emits one result per cycle into the
// output register, which the consumer may stall; a new request is taken as
// soon as the last pixel has entered that register. error results are
// single pixels of color zero at the current position, which does not move.
// the palette is not cleared by reset and must be written before use.
module rle_palette_pixel_decoder_unit
  import rpd_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COLOR_BITS      = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output out_res_t         out_data,
  // configuration writes
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // state and registers
  state_t           state_r,      state_nxt;
  logic [POS_W-1:0] pos_r,        pos_nxt;
  logic [6:0]       pend_cnt_r,   pend_cnt_nxt;
  pend_kind_t       pend_kind_r,  pend_kind_nxt;
  logic [5:0]       run_left_r,   run_left_nxt;
  err_code_t        run_err_r,    run_err_nxt;
  logic             run_zero_r,   run_zero_nxt;
  logic             out_valid_r,  out_valid_nxt;
  out_res_t         out_data_r,   out_data_nxt;
  logic [POS_W-1:0] total_r;
  logic             bitmap_r;

  // request decode
  logic                  accept;
  logic [1:0]            sel;
  logic [5:0]            len6;
  logic [6:0]            ctl_len;
  logic [6:0]            chk_len;
  logic                  over;
  logic                  in_range;
  logic                  pal_wr_en;
  logic                  pal_rd_en;
  logic [COLOR_BITS-1:0] pal_rd_data;
  logic                  emit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign sel      = in_data.data_byte[7:6];
  assign len6     = in_data.data_byte[5:0];
  assign ctl_len  = (sel == SEL_LIT_LONG) ? {1'b1, len6} : {1'b0, len6};
  assign in_range = ({1'b0, in_data.data_byte} < 9'(PALETTE_ENTRIES));

  // length checked against the room left: one adder serves control and literal requests
  always_comb begin
    if (in_data.req_type == REQ_CTRL) begin
      chk_len = ctl_len;
    end else if (bitmap_r || (pend_kind_r == PEND_LIT)) begin
      chk_len = 7'd1;
    end else begin
      chk_len = pend_cnt_r;
    end
  end

  // len > room left, with room clamped at zero once the position passes the total
  assign over = (chk_len != 7'd0) &&
                (({1'b0, pos_r} + (POS_W + 1)'(chk_len)) > {1'b0, total_r});

  assign emit = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_kind_nxt = pend_kind_r;
    run_left_nxt  = run_left_r;
    run_err_nxt   = run_err_r;
    run_zero_nxt  = run_zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pal_wr_en     = 1'b0;
    pal_rd_en     = 1'b0;

    if (accept) begin
      case (in_data.req_type)
        REQ_START: begin
          pos_nxt       = '0;
          pend_cnt_nxt  = '0;
          pend_kind_nxt = PEND_NONE;
        end
        REQ_PAL: begin
          pal_wr_en = in_range;
        end
        REQ_CTRL: begin
          if (!bitmap_r) begin
            if (pend_kind_r != PEND_NONE) begin
              // control byte dropped, pending run abandoned
              pend_kind_nxt = PEND_NONE;
              pend_cnt_nxt  = '0;
              state_nxt     = ST_RUN;
              run_left_nxt  = 6'd1;
              run_err_nxt   = ERR_PENDING;
              run_zero_nxt  = 1'b1;
            end else if (over) begin
              state_nxt    = ST_RUN;
              run_left_nxt = 6'd1;
              run_err_nxt  = ERR_OVER;
              run_zero_nxt = 1'b1;
            end else begin
              case (sel)
                SEL_ZERO: begin
                  if (len6 != 6'd0) begin
                    state_nxt    = ST_RUN;
                    run_left_nxt = len6;
                    run_err_nxt  = ERR_NONE;
                    run_zero_nxt = 1'b1;
                  end
                end
                SEL_FILL: begin
                  pend_kind_nxt = PEND_FILL;
                  pend_cnt_nxt  = ctl_len;
                end
                default: begin
                  if (ctl_len != 7'd0) begin
                    pend_kind_nxt = PEND_LIT;
                    pend_cnt_nxt  = ctl_len;
                  end
                end
              endcase
            end
          end
        end
        default: begin
          // literal byte
          state_nxt    = ST_RUN;
          run_left_nxt = 6'd1;
          run_err_nxt  = ERR_NONE;
          run_zero_nxt = 1'b1;
          if (!bitmap_r && (pend_kind_r == PEND_LIT)) begin
            pend_cnt_nxt = pend_cnt_r - 7'd1;
            if (pend_cnt_r == 7'd1) begin
              pend_kind_nxt = PEND_NONE;
            end
          end else if (!bitmap_r && (pend_kind_r == PEND_FILL)) begin
            pend_kind_nxt = PEND_NONE;
            pend_cnt_nxt  = '0;
            run_left_nxt  = pend_cnt_r[5:0];
          end
          if (!bitmap_r && (pend_kind_r == PEND_NONE)) begin
            run_err_nxt = ERR_UNEXP;
          end else if (over) begin
            run_err_nxt  = ERR_OVER;
            run_left_nxt = 6'd1;
          end else if (!bitmap_r && (pend_kind_r == PEND_FILL) &&
                       (pend_cnt_r == 7'd0)) begin
            // empty fill only swallows its literal
            state_nxt = ST_IDLE;
          end else begin
            pal_rd_en    = 1'b1;
            run_zero_nxt = !in_range;
          end
        end
      endcase
    end

    // pixel loop, one result per cycle into the output register unless the consumer stalls it
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.pixel_color = run_zero_r ? '0 : COLOR_W'(pal_rd_data);
      out_data_nxt.pixel_index = pos_r[INDEX_W-1:0];
      out_data_nxt.last_of_run = (run_left_r == 6'd1);
      out_data_nxt.error_code  = run_err_r;
      if (run_err_r == ERR_NONE) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      run_left_nxt = run_left_r - 6'd1;
      if (run_left_r == 6'd1) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      pend_cnt_r  <= '0;
      pend_kind_r <= PEND_NONE;
      run_left_r  <= '0;
      run_err_r   <= ERR_NONE;
      run_zero_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      pend_kind_r <= pend_kind_nxt;
      run_left_r  <= run_left_nxt;
      run_err_r   <= run_err_nxt;
      run_zero_r  <= run_zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      bitmap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_TOTAL: total_r  <= cfg_data[POS_W-1:0];
        CFG_BITMAP_MODE: bitmap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rpd_palette #(
    .ENTRIES (PALETTE_ENTRIES),
    .WIDTH   (COLOR_BITS),
    .ADDR_W  (PAL_AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (in_data.data_byte[PAL_AW-1:0]),
    .wr_data (in_data.color_word[COLOR_BITS-1:0]),
    .rd_en   (pal_rd_en),
    .rd_addr (in_data.data_byte[PAL_AW-1:0]),
    .rd_data (pal_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // error results are always single and final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.error_code != ERR_NONE)) |-> out_data_r.last_of_run)
    else $error("error result without last_of_run");

  // a start-image request rewinds the position
  a_start_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_START)) |=> (pos_r == '0))
    else $error("position not cleared by start image");

  // a pending literal run always has bytes left
  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_kind_r == PEND_LIT) |-> (pend_cnt_r != 7'd0))
    else $error("pending literal run with zero count");

  // the pixel loop never runs with nothing left to emit
  a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (run_left_r != 6'd0))
    else $error("pixel loop active with zero pixels left");
`endif

endmodule
